FILE: hdl/dks_pkg.sv
// Shared sizes, payload types and controller/datapath command structs
// for the descending key/tag sorter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dks_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_BITS  = 32;
	localparam int TAG_BITS  = 20;
	// count must be able to hold MAX_ITEMS itself
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// controller -> datapath
	typedef struct packed {
		logic ins;    // place the incoming pair
		logic pop;    // shift the head pair out
	} dks_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;      // store holds MAX_ITEMS pairs
		logic last_one;  // exactly one pair left
	} dks_sts_t;

endpackage

`default_nettype wire

FILE: hdl/descending_key_tag_sort.sv
// Top level: descending key/tag sorter. One pair placed per cycle while
// loading; the pair flagged last_item closes the set. Results are one beat
// per cycle on strobe and the receiver cannot stall.
// The first result beat is on the ports in the cycle right after the edge
// that accepts the last_item pair; a set of n held pairs then emits n beats
// back to back. Each new key is compared across the whole cell row at once;
// no pair is taken while busy, and a pair that meets a full store is dropped
// and raises items_dropped. Reset (arst_n low) empties the store.
`timescale 1ns / 1ps
`default_nettype none

module descending_key_tag_sort (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [31:0]          prob_key,
	input  wire logic [19:0]          word_tag,
	input  wire logic                 last_item,
	output logic                      strobe,
	output logic [31:0]               out_key,
	output logic [19:0]               out_tag,
	output logic                      out_last,
	output logic                      items_dropped
);

	dks_pkg::dks_cmd_t cmd;
	dks_pkg::dks_sts_t sts;

	dks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (last_item),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.strobe    (strobe)
	);

	dks_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_key    (prob_key),
		.in_tag    (word_tag),
		.sts       (sts),
		.head_key  (out_key),
		.head_tag  (out_tag),
		.head_last (out_last),
		.ovf       (items_dropped)
	);

endmodule

`default_nettype wire

FILE: hdl/dks_ctrl.sv
// Controller FSM for the sorter: load phase and emission phase.
// Depends on dks_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dks_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              last_item,
	input  wire dks_pkg::dks_sts_t sts,
	output dks_pkg::dks_cmd_t      cmd,
	output logic                   busy,
	output logic                   strobe
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd.ins = 1'b0;
		cmd.pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ins = accept;
				if (accept && last_item) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.pop = 1'b1;
				if (sts.last_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = (state_q == ST_EMIT);

endmodule

`default_nettype wire

FILE: hdl/dks_datapath.sv
// Row of sort cells (parallel insertion), fill count and overflow flag.
// Depends on dks_pkg for sizes, payload types and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module dks_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dks_pkg::dks_cmd_t cmd,
	input  wire dks_pkg::key_t     in_key,
	input  wire dks_pkg::tag_t     in_tag,
	output dks_pkg::dks_sts_t      sts,
	output dks_pkg::key_t          head_key,
	output dks_pkg::tag_t          head_tag,
	output logic                   head_last,
	output logic                   ovf
);

	dks_pkg::key_t key_q [dks_pkg::MAX_ITEMS];
	dks_pkg::tag_t tag_q [dks_pkg::MAX_ITEMS];
	dks_pkg::key_t key_d [dks_pkg::MAX_ITEMS];
	dks_pkg::tag_t tag_d [dks_pkg::MAX_ITEMS];
	logic [dks_pkg::MAX_ITEMS-1:0] ge;
	dks_pkg::cnt_t count_q;
	logic          ovf_q;
	logic          full;

	assign full = (count_q == dks_pkg::CNT_W'(dks_pkg::MAX_ITEMS));

	// held cell whose key is not below the new key keeps its place;
	// occupied cells form a descending prefix, so ge is a prefix mask
	always_comb begin
		for (int i = 0; i < dks_pkg::MAX_ITEMS; i++) begin
			ge[i] = (dks_pkg::CNT_W'(i) < count_q) && (key_q[i] >= in_key);
		end
	end

	// per-cell next value: hold, take new pair, shift down, or shift up on pop
	for (genvar i = 0; i < dks_pkg::MAX_ITEMS; i++) begin : g_cell
		dks_pkg::key_t up_key, dn_key;
		dks_pkg::tag_t up_tag, dn_tag;
		logic          take_new;

		if (i == 0) begin : g_first
			assign dn_key   = in_key;
			assign dn_tag   = in_tag;
			assign take_new = 1'b1;
		end else begin : g_rest
			assign dn_key   = key_q[i-1];
			assign dn_tag   = tag_q[i-1];
			assign take_new = ge[i-1];
		end

		if (i == dks_pkg::MAX_ITEMS - 1) begin : g_tail
			assign up_key = key_q[i];
			assign up_tag = tag_q[i];
		end else begin : g_body
			assign up_key = key_q[i+1];
			assign up_tag = tag_q[i+1];
		end

		always_comb begin
			key_d[i] = key_q[i];
			tag_d[i] = tag_q[i];
			priority if (cmd.pop) begin
				key_d[i] = up_key;
				tag_d[i] = up_tag;
			end else if (cmd.ins && !full && !ge[i]) begin
				key_d[i] = take_new ? in_key : dn_key;
				tag_d[i] = take_new ? in_tag : dn_tag;
			end
		end

		always_ff @(posedge clk) begin
			key_q[i] <= key_d[i];
			tag_q[i] <= tag_d[i];
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.pop) begin
			count_q <= count_q - dks_pkg::CNT_W'(1);
			if (sts.last_one) begin
				ovf_q <= 1'b0;
			end
		end else if (cmd.ins) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + dks_pkg::CNT_W'(1);
			end
		end
	end

	assign sts.full     = full;
	assign sts.last_one = (count_q == dks_pkg::CNT_W'(1));
	assign head_key     = key_q[0];
	assign head_tag     = tag_q[0];
	assign head_last    = sts.last_one;
	assign ovf          = ovf_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dks_pkg::CNT_W'(dks_pkg::MAX_ITEMS))
		else $error("fill count above capacity");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop from empty store");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.pop))
		else $error("insert and pop in same cycle");

	a_run_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && sts.last_one) |=> (count_q == '0 && !ovf_q))
		else $error("store not empty after final beat");
`endif

endmodule

`default_nettype wire
